// ===== src/prms_pkg.sv =====
// Shared types and constants of the PDF revision marker scanner.
package prms_pkg;

    typedef logic [7:0] t_byte;

    // Bytes of history kept in front of the current byte.
    localparam int WIN_DEPTH = 9;

    // Emitted count fields are clamped to this value.
    localparam logic [15:0] FIELD_MAX = 16'hFFFF;

    // Tamper score, in units of 0.05.
    localparam logic [4:0] SCORE_CAP     = 5'd20;
    localparam logic [4:0] SCORE_PER_REV = 5'd6;
    localparam logic [4:0] SCORE_PREV    = 5'd5;
    localparam logic [4:0] SCORE_SIG     = 5'd5;

    // Packed result: eof, prev, signature, extra, score, zero fill to 56 bits.
    localparam int OUT_BITS = 56;

    localparam t_byte MK_EOF [5] = '{8'h25, 8'h25, 8'h45, 8'h4F, 8'h46};
    localparam t_byte MK_PREV[5] = '{8'h2F, 8'h50, 8'h72, 8'h65, 8'h76};
    localparam t_byte MK_SIG_A[9] =
        '{8'h2F, 8'h54, 8'h79, 8'h70, 8'h65, 8'h2F, 8'h53, 8'h69, 8'h67};
    localparam t_byte MK_SIG_B[10] =
        '{8'h2F, 8'h54, 8'h79, 8'h70, 8'h65, 8'h20, 8'h2F, 8'h53, 8'h69, 8'h67};

endpackage

// ===== src/pdf_revision_marker_scanner.sv =====
// Top level of the PDF revision marker scanner: byte window, marker counters and result.
//
// The block takes one document byte per request on the slave side, the last byte of the
// document flagged by s_axis_tlast, and sustains one byte per clock cycle. Each byte, together
// with the nine bytes before it, is compared against the markers "%%EOF", "/Prev",
// "/Type/Sig" and "/Type /Sig"; end-of-file and previous-revision markers are counted in
// saturating counters of COUNT_BITS bits and a signature marker sets a sticky flag. When the
// last byte is processed a single result request is presented on the master side, through
// one input register and one result register, and the window, the counters and the flag
// are cleared so that the following byte starts a new document.
// Non-final bytes produce no result. Byte acceptance only pauses when the last byte of a
// document sits in the input register while the previous document's result is still waiting
// in the result register and is not taken in that cycle; otherwise the block takes a byte
// every cycle regardless of the master side. The score counts 6 per extra revision, plus 5
// when any previous-revision marker was seen, clamped to 20, and 5 more (clamped again) when
// a signature is present alongside extra revisions; 20 corresponds to a likelihood of 1.0.
module pdf_revision_marker_scanner #(
    parameter int COUNT_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  prms_pkg::t_byte               s_axis_tdata,  // [7:0] data_byte
    input  logic                          s_axis_tlast,  // end_of_doc
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [15:0] eof_markers, [31:16] prev_markers, [32] signature_seen,
    // [48:33] extra_revisions, [53:49] tamper_score, [55:54] zero
    output logic [prms_pkg::OUT_BITS-1:0] m_axis_tdata
);
    import prms_pkg::*;

    // Width wide enough for both a counter and the 16-bit output fields.
    localparam int WideBits = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [COUNT_BITS-1:0] CountMax = '1;

    // Input register.
    logic                  r_in_valid;
    t_byte                 r_in_byte;
    logic                  r_in_last;

    // Document state.
    t_byte                 r_win [WIN_DEPTH];
    logic [COUNT_BITS-1:0] r_eof;
    logic [COUNT_BITS-1:0] r_prev;
    logic                  r_sig;

    // Result register.
    logic                  r_out_valid;
    logic [OUT_BITS-1:0]   r_out_data;

    logic                  w_advance;
    logic                  w_emit;
    t_byte                 w_buf [WIN_DEPTH+1];
    logic                  w_hit_eof;
    logic                  w_hit_prev;
    logic                  w_hit_sig;
    logic                  w_hit_sig_b;
    logic [COUNT_BITS-1:0] n_eof;
    logic [COUNT_BITS-1:0] n_prev;
    logic                  n_sig;
    logic [COUNT_BITS-1:0] w_extra;
    logic [5:0]            w_score_base;
    logic [5:0]            w_score_prev;
    logic [5:0]            w_score_sig;
    logic [WideBits-1:0]   w_eof_wide;
    logic [WideBits-1:0]   w_prev_wide;
    logic [WideBits-1:0]   w_extra_wide;
    logic [15:0]           w_eof_field;
    logic [15:0]           w_prev_field;
    logic [15:0]           w_extra_field;
    logic [OUT_BITS-1:0]   n_out_data;

    // The held byte moves on unless it is a last byte and the result slot is still occupied and not being taken.
    assign w_advance     = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign w_emit        = w_advance && r_in_last;
    assign s_axis_tready = !r_in_valid || w_advance;

    // Marker comparison against the tail of the window plus the current byte.
    always_comb begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
            w_buf[i] = r_win[i];
        end
        w_buf[WIN_DEPTH] = r_in_byte;

        w_hit_eof  = 1'b1;
        w_hit_prev = 1'b1;
        for (int k = 0; k < 5; k++) begin
            if (w_buf[WIN_DEPTH-4+k] != MK_EOF[k]) begin
                w_hit_eof = 1'b0;
            end
            if (w_buf[WIN_DEPTH-4+k] != MK_PREV[k]) begin
                w_hit_prev = 1'b0;
            end
        end

        w_hit_sig = 1'b1;
        for (int k = 0; k < 9; k++) begin
            if (w_buf[1+k] != MK_SIG_A[k]) begin
                w_hit_sig = 1'b0;
            end
        end
        w_hit_sig_b = 1'b1;
        for (int k = 0; k < 10; k++) begin
            if (w_buf[k] != MK_SIG_B[k]) begin
                w_hit_sig_b = 1'b0;
            end
        end
        w_hit_sig = w_hit_sig || w_hit_sig_b;
    end

    // Saturating counter updates including the current byte.
    always_comb begin
        n_eof  = (w_hit_eof && r_eof != CountMax) ? r_eof + COUNT_BITS'(1) : r_eof;
        n_prev = (w_hit_prev && r_prev != CountMax) ? r_prev + COUNT_BITS'(1) : r_prev;
        n_sig  = r_sig || w_hit_sig;
    end

    // Result fields and score.
    always_comb begin
        w_extra = (n_eof != '0) ? n_eof - COUNT_BITS'(1) : '0;

        if (w_extra >= COUNT_BITS'(4)) begin
            w_score_base = 6'(SCORE_CAP);
        end else begin
            w_score_base = 6'(w_extra[1:0]) * 6'(SCORE_PER_REV);
        end

        w_score_prev = w_score_base + ((n_prev != '0) ? 6'(SCORE_PREV) : 6'd0);
        if (w_score_prev > 6'(SCORE_CAP)) begin
            w_score_prev = 6'(SCORE_CAP);
        end

        w_score_sig = w_score_prev;
        if (n_sig && w_extra != '0) begin
            w_score_sig = w_score_prev + 6'(SCORE_SIG);
            if (w_score_sig > 6'(SCORE_CAP)) begin
                w_score_sig = 6'(SCORE_CAP);
            end
        end

        w_eof_wide   = WideBits'(n_eof);
        w_prev_wide  = WideBits'(n_prev);
        w_extra_wide = WideBits'(w_extra);
        w_eof_field   = (w_eof_wide > WideBits'(FIELD_MAX)) ? FIELD_MAX : w_eof_wide[15:0];
        w_prev_field  = (w_prev_wide > WideBits'(FIELD_MAX)) ? FIELD_MAX : w_prev_wide[15:0];
        w_extra_field = (w_extra_wide > WideBits'(FIELD_MAX)) ? FIELD_MAX : w_extra_wide[15:0];

        n_out_data = {2'b00, w_score_sig[4:0], w_extra_field, n_sig,
                      w_prev_field, w_eof_field};
    end

    // Control and document state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_eof       <= '0;
            r_prev      <= '0;
            r_sig       <= 1'b0;
            for (int i = 0; i < WIN_DEPTH; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (w_emit) begin
                // End of document: back to the state after reset.
                r_eof  <= '0;
                r_prev <= '0;
                r_sig  <= 1'b0;
                for (int i = 0; i < WIN_DEPTH; i++) begin
                    r_win[i] <= '0;
                end
            end else if (w_advance) begin
                r_eof  <= n_eof;
                r_prev <= n_prev;
                r_sig  <= n_sig;
                for (int i = 0; i < WIN_DEPTH; i++) begin
                    r_win[i] <= w_buf[i+1];
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (w_emit) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // The score never leaves its range.
    a_score_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[53:49] <= SCORE_CAP))
        else $error("tamper score above cap");

    // Without extra revisions only the previous-revision bonus can apply.
    a_score_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[48:33] == 16'd0) |-> (m_axis_tdata[53:49] <= SCORE_PREV))
        else $error("score without extra revisions too high");

    // Extra revisions follow the end-of-file count.
    a_extra_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[15:0] != 16'd0 && m_axis_tdata[15:0] != FIELD_MAX)
        |-> (m_axis_tdata[48:33] == m_axis_tdata[15:0] - 16'd1))
        else $error("extra revisions do not match end-of-file count");

    // A new result is only loaded once the previous one has been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("pending result overwritten");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the PDF revision marker scanner, with driver and monitor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import prms_pkg::*;

    // Each side idles on roughly this many cycles in a hundred.
    localparam int IDLE_PCT     = 11;
    // Length of the long receiver hold-off that fills the block up.
    localparam int HOLD_CYCLES  = 300;
    // Random stimulus stops once this many bytes have been queued.
    localparam int RANDOM_BYTES = 2000;
    // Cycles allowed after the last expected result.
    localparam int SETTLE       = 8;
    // Cycle limit at which a hung run is ended as a failure.
    localparam longint CYCLE_LIMIT = 100_000;
    localparam int MAX_PRINTS   = 40;

    // Score arithmetic, in units of 0.05.
    localparam logic [5:0] SCORE_MAX  = 6'd20;
    localparam logic [5:0] PER_REV    = 6'd6;
    localparam logic [5:0] PREV_BONUS = 6'd5;
    localparam logic [5:0] SIG_BONUS  = 6'd5;
    localparam logic [15:0] COUNT_TOP = 16'hFFFF;

    typedef enum int {M_EOF, M_PREV, M_SIG_A, M_SIG_B, NUM_MARKERS} t_marker;

    typedef struct packed {
        t_byte data;
        logic  last;
    } t_doc_byte;

    typedef struct packed {
        logic [15:0] eof;
        logic [15:0] prev;
        logic        sig;
        logic [15:0] extra;
        logic [4:0]  score;
    } t_doc_report;

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    t_byte               s_axis_tdata  = '0;     // [7:0] data_byte
    logic                s_axis_tlast  = 1'b0;   // end_of_doc
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // [15:0] eof_markers, [31:16] prev_markers, [32] signature_seen,
    // [48:33] extra_revisions, [53:49] tamper_score, [55:54] zero
    logic [OUT_BITS-1:0] m_axis_tdata;

    string markers [NUM_MARKERS] = '{"%%EOF", "/Prev", "/Type/Sig", "/Type /Sig"};

    // Bytes waiting to be offered, and document reports waiting to be seen.
    t_doc_byte   byte_q[$];
    t_doc_report report_q[$];

    // Mirror of the scanner: history window, counters and signature flag.
    t_byte       hist     [WIN_DEPTH];
    t_byte       scan_buf [WIN_DEPTH+1];
    logic [15:0] eof_cnt;
    logic [15:0] prev_cnt;
    logic        sig_flag;

    // Handshake bookkeeping used by the clocked processes.
    logic        in_fire = 1'b0;
    logic        steady  = 1'b0;
    int          hold_asks = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    // Run statistics.
    int          errors = 0;
    int          bytes_queued = 0;
    int          bytes_sent = 0;
    int          docs_scanned = 0;
    int          sig_docs = 0;
    int          stall_cycles = 0;
    logic [15:0] top_eof = '0;
    longint      cycles = 0;

    t_doc_byte           next_byte;
    t_doc_report         want;
    logic [OUT_BITS-1:0] got;

    pdf_revision_marker_scanner dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Guard against a hung run: anything that stops the flow ends here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input longint unsigned exp_val,
                                 input longint unsigned got_val);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch on %s at cycle %0d: expected %0d, got %0d",
                     what, cycles, exp_val, got_val);
    endtask

    task automatic clear_scan();
        int i;
        for (i = 0; i < WIN_DEPTH; i++)
            hist[i] = '0;
        eof_cnt  = '0;
        prev_cnt = '0;
        sig_flag = 1'b0;
    endtask

    // True when the marker ends exactly at the current byte.
    function automatic bit tail_is(input string mk);
        int n;
        int k;
        bit hit;
        n = mk.len();
        hit = 1'b1;
        for (k = 0; k < n; k++)
            if (scan_buf[WIN_DEPTH + 1 - n + k] != t_byte'(mk[k]))
                hit = 1'b0;
        return hit;
    endfunction

    // Advances the mirror by one accepted byte; the final byte of a document
    // yields the report that the block should send, then clears the mirror.
    task automatic scan_byte(input t_byte b, input logic last);
        t_doc_report r;
        logic [15:0] extra;
        logic [5:0]  score;
        int          i;
        for (i = 0; i < WIN_DEPTH; i++)
            scan_buf[i] = hist[i];
        scan_buf[WIN_DEPTH] = b;

        if (tail_is(markers[M_EOF]) && eof_cnt != COUNT_TOP)
            eof_cnt++;
        if (tail_is(markers[M_PREV]) && prev_cnt != COUNT_TOP)
            prev_cnt++;
        if (tail_is(markers[M_SIG_A]) || tail_is(markers[M_SIG_B]))
            sig_flag = 1'b1;

        for (i = 0; i < WIN_DEPTH; i++)
            hist[i] = scan_buf[i+1];

        if (last) begin
            extra = (eof_cnt != '0) ? eof_cnt - 16'd1 : 16'd0;
            // Four extra revisions already reach the cap.
            score = (extra >= 16'd4) ? SCORE_MAX : 6'(extra[1:0]) * PER_REV;
            if (prev_cnt != '0)
                score += PREV_BONUS;
            if (score > SCORE_MAX)
                score = SCORE_MAX;
            if (sig_flag && extra != '0) begin
                score += SIG_BONUS;
                if (score > SCORE_MAX)
                    score = SCORE_MAX;
            end
            r.eof   = eof_cnt;
            r.prev  = prev_cnt;
            r.sig   = sig_flag;
            r.extra = extra;
            r.score = score[4:0];
            report_q.push_back(r);

            docs_scanned++;
            if (sig_flag)
                sig_docs++;
            if (eof_cnt > top_eof)
                top_eof = eof_cnt;
            clear_scan();
        end
    endtask

    // Monitor: every accepted byte feeds the mirror, every accepted result
    // is checked against the oldest outstanding report.
    always @(posedge i_clk) begin
        in_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && !s_axis_tready)
            stall_cycles++;
        if (in_fire) begin
            bytes_sent++;
            scan_byte(s_axis_tdata, s_axis_tlast);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (report_q.size() == 0) begin
                flag_mismatch("unexpected result request", 0, got[53:0]);
            end else begin
                want = report_q.pop_front();
                if (got[15:0] != want.eof)
                    flag_mismatch("eof_markers", want.eof, got[15:0]);
                if (got[31:16] != want.prev)
                    flag_mismatch("prev_markers", want.prev, got[31:16]);
                if (got[32] != want.sig)
                    flag_mismatch("signature_seen", want.sig, got[32]);
                if (got[48:33] != want.extra)
                    flag_mismatch("extra_revisions", want.extra, got[48:33]);
                if (got[53:49] != want.score)
                    flag_mismatch("tamper_score", want.score, got[53:49]);
                if (got[55:54] != '0)
                    flag_mismatch("zero fill", 0, got[55:54]);
            end
        end
    end

    // Driver: a new byte is presented only once the current request has been
    // taken, so valid never drops while a byte is still on offer.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (byte_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                next_byte = byte_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_byte.data;
                s_axis_tlast  <= next_byte.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off whenever one is asked for.
    always @(negedge i_clk) begin
        if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= i_rst_n && (steady || $urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic push_byte(input t_byte b, input logic last);
        t_doc_byte item;
        item.data = b;
        item.last = last;
        byte_q.push_back(item);
        bytes_queued++;
    endtask

    task automatic push_text(input string s, input logic ends_doc);
        int k;
        for (k = 0; k < s.len(); k++)
            push_byte(t_byte'(s[k]), ends_doc && (k == s.len() - 1));
    endtask

    // Builds one random document: whole markers among noise, with
    // truncated and corrupted markers mixed in to probe near misses.
    task automatic gen_doc();
        t_byte body[$];
        string mk;
        int    chunks;
        int    c;
        int    k;
        int    w;
        int    cut;
        chunks = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (c = 0; c < chunks; c++) begin
            w  = $urandom_range(99);
            mk = markers[$urandom_range(0, NUM_MARKERS - 1)];
            if (w < 30) begin
                repeat ($urandom_range(1, 6))
                    body.push_back(t_byte'($urandom));
            end else if (w < 65) begin
                for (k = 0; k < mk.len(); k++)
                    body.push_back(t_byte'(mk[k]));
            end else if (w < 78) begin
                cut = $urandom_range(1, mk.len() - 1);
                for (k = 0; k < cut; k++)
                    body.push_back(t_byte'(mk[k]));
            end else if (w < 90) begin
                cut = $urandom_range(0, mk.len() - 1);
                for (k = 0; k < mk.len(); k++)
                    body.push_back((k == cut) ? t_byte'($urandom) : t_byte'(mk[k]));
            end else begin
                // A run of end-of-file markers pushes the revision count up.
                mk = markers[M_EOF];
                repeat ($urandom_range(1, 3))
                    for (k = 0; k < mk.len(); k++)
                        body.push_back(t_byte'(mk[k]));
            end
        end
        for (k = 0; k < body.size(); k++)
            push_byte(body[k], k == body.size() - 1);
    endtask

    // Waits until every queued byte has gone and every
    // expected report has arrived, then lets the pipeline settle.
    task automatic drain_all();
        while (byte_q.size() != 0 || s_axis_tvalid || report_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    initial begin
        int d;
        int n;
        clear_scan();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed documents: byte extremes, each marker, overlap, near misses,
        // a marker cut by a document boundary and the score reaching its cap.
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_text("%%EOF", 1'b1);
        push_text("%%%EOF", 1'b1);
        push_text("/Prev%%EOF%%EOF", 1'b1);
        push_text("/Type/Sig%%EOF%%EOF", 1'b1);
        push_text("/Type /Sig%%EOF%%EOF%%EOF/Prev", 1'b1);
        push_text("/Type  /Sig/TypeX/Sig%%EOF%%EOF", 1'b1);
        push_text("%%EO", 1'b1);
        push_text("F", 1'b1);
        push_text("%%EOF%%EOF%%EOF%%EOF%%EOF/Prev", 1'b1);
        push_text("/Type/Sig/Prev", 1'b1);
        drain_all();

        // Receiver holds off for a long stretch while short documents keep
        // coming, so the result register fills and the input has to stall.
        hold_asks++;
        for (d = 0; d < 40; d++) begin
            n = $urandom_range(1, 4);
            repeat (n - 1)
                push_byte(t_byte'($urandom), 1'b0);
            push_byte(t_byte'($urandom), 1'b1);
        end
        drain_all();

        // Random documents, fed a little at a time so that the quiet band in
        // the middle lines up with the bytes actually being sent.
        d = 0;
        bytes_queued = 0;
        while (bytes_queued < RANDOM_BYTES) begin
            while (byte_q.size() > 64)
                @(negedge i_clk);
            steady = (d >= 30 && d < 50);
            gen_doc();
            d++;
        end
        drain_all();
        steady = 1'b0;

        $display("Scanned %0d bytes in %0d documents, %0d of them signed.",
                 bytes_sent, docs_scanned, sig_docs);
        $display("Highest end-of-file count %0d; input stalled on %0d cycles (hold-off %0d).",
                 top_eof, stall_cycles, HOLD_CYCLES);
        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ===== pdf_revision_marker_scanner.f =====
src/prms_pkg.sv
src/pdf_revision_marker_scanner.sv
sim/tb.sv
